/* rtl/core/descriptor_slot_allocator_core_defines.svh */
// ----------------------------------------------------------------------------
// Descriptor slot allocator assertion macros
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle property.
`define DSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define DSA_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/dsa_pkg.sv */
// ----------------------------------------------------------------------------
// Descriptor slot allocator package
// Widths, map geometry, operation/status/register codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsa_pkg;

  localparam int SLOT_COUNT   = 1024;
  localparam int SLOT_W       = 10;
  localparam int INDEX_LIMIT  = 1 << SLOT_W;
  localparam int SEARCH_LIMIT = (SLOT_COUNT < INDEX_LIMIT) ? SLOT_COUNT : INDEX_LIMIT;

  // Free map is stored as rows of used bits
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int ROW_COUNT = (SLOT_COUNT + WORD_W - 1) / WORD_W;
  localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int LAST_ROW  = (SEARCH_LIMIT - 1) / WORD_W;
  localparam int LAST_BITS = SEARCH_LIMIT - LAST_ROW * WORD_W;

  typedef logic [WORD_W-1:0] word_t;

  // Slots of the last searched row that lie below the search limit
  localparam word_t LAST_MASK = ~(word_t'('1) << LAST_BITS);

  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int INCR_W     = 9;
  localparam int HANDLE_W   = 64;
  localparam int PROD_W     = SLOT_W + INCR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [INCR_W-1:0] INCR_RESET = INCR_W'(32);

  typedef enum logic [OP_W-1:0] {
    OP_AUTO  = 2'd0,
    OP_FIXED = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_IN_USE  = 2'd1,
    ST_NO_FREE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_START  = 2'd0,
    CFG_HANDLE_INCR = 2'd1,
    CFG_CPU_BASE    = 2'd2,
    CFG_GPU_BASE    = 2'd3
  } cfg_reg_e;

endpackage

/* rtl/core/dsa_if.sv */
// ----------------------------------------------------------------------------
// Descriptor slot allocator channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dsa_req_if;
  logic                          valid;
  logic                          ready;
  logic [dsa_pkg::OP_W-1:0]      operation;
  logic [dsa_pkg::SLOT_W-1:0]    slot_index;

  modport source (output valid, output operation, output slot_index, input ready);
  modport sink   (input valid, input operation, input slot_index, output ready);
endinterface

interface dsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dsa_pkg::STATUS_W-1:0]  status;
  logic [dsa_pkg::SLOT_W-1:0]    granted_slot;
  logic [dsa_pkg::HANDLE_W-1:0]  cpu_handle;
  logic [dsa_pkg::HANDLE_W-1:0]  gpu_handle;

  modport source (output valid, output status, output granted_slot, output cpu_handle,
                  output gpu_handle, input ready);
  modport sink   (input valid, input status, input granted_slot, input cpu_handle,
                  input gpu_handle, output ready);
endinterface

/* rtl/core/descriptor_slot_allocator_core.sv */
// ----------------------------------------------------------------------------
// Descriptor slot allocator core
// First-fit allocator over a bitmap of descriptor slots with handle math.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : one transfer per operation (auto request, fixed request, free).
//   rsp_o  : exactly one transfer per request: status, slot and CPU/GPU
//            handles (base + slot * increment).
//   cfg_*  : register writes, only while no request is in flight.
// Timing: the map is held as 32-bit rows of used bits in an array with separate
//   read and write ports; the sequencer reads one row per cycle.
//   Auto request: accept, row read, one evaluation per scanned row (up to 32),
//     multiply, add, output load. Fixed request: the same with one row.
//   Free and failing requests skip multiply and add; operation code 3 and
//   out-of-range requests go from accept straight to the output load.
//   Throughput is one operation at a time; req_i.ready is high only while
//   the sequencer is idle.
// Reset: every slot reads as free (per-row valid bits, no clearing pass);
//   config registers take their reset values.
// Stall: the response sits in an output register; the next request is
//   accepted meanwhile, and its result waits until that register drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "descriptor_slot_allocator_core_defines.svh"

module descriptor_slot_allocator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dsa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  dsa_req_if.sink                        req_i,
  dsa_rsp_if.source                      rsp_o
);

  localparam int ROW_W  = dsa_pkg::ROW_W;
  localparam int BIT_W  = dsa_pkg::BIT_W;
  localparam int SLOT_W = dsa_pkg::SLOT_W;
  localparam logic [ROW_W-1:0] LAST_ROW_IDX = ROW_W'(dsa_pkg::LAST_ROW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_MUL,
    S_ADD,
    S_DONE
  } state_e;

  // Configuration registers
  logic [SLOT_W-1:0]              auto_start_q;
  logic [dsa_pkg::INCR_W-1:0]     incr_q;
  logic [dsa_pkg::HANDLE_W-1:0]   cpu_base_q;
  logic [dsa_pkg::HANDLE_W-1:0]   gpu_base_q;

  // Sequencer
  state_e                         state_q;
  dsa_pkg::op_e                   op_q;
  logic [SLOT_W-1:0]              slot_q;
  logic [ROW_W-1:0]               row_q;
  logic                           first_q;
  dsa_pkg::status_e               res_status_q;
  logic [SLOT_W-1:0]              res_slot_q;
  logic                           hnd_q;
  logic [dsa_pkg::PROD_W-1:0]     prod_q;
  logic [dsa_pkg::HANDLE_W-1:0]   cpu_sum_q;
  logic [dsa_pkg::HANDLE_W-1:0]   gpu_sum_q;

  // Output register
  logic                           rsp_valid_q;
  dsa_pkg::status_e               rsp_status_q;
  logic [SLOT_W-1:0]              rsp_slot_q;
  logic [dsa_pkg::HANDLE_W-1:0]   rsp_cpu_q;
  logic [dsa_pkg::HANDLE_W-1:0]   rsp_gpu_q;
  logic                           rsp_load;

  // Map storage: used bits per row, row invalid means all free
  dsa_pkg::word_t                 used_mem [dsa_pkg::ROW_COUNT];
  logic [dsa_pkg::ROW_COUNT-1:0]  row_valid_q;
  dsa_pkg::word_t                 rd_data_q;
  logic                           rd_valid_q;
  logic [ROW_W-1:0]               rd_addr;
  logic                           mem_we;
  dsa_pkg::word_t                 mem_wdata;

  dsa_pkg::word_t                 free_word;
  dsa_pkg::word_t                 start_mask;
  dsa_pkg::word_t                 cand;
  logic                           hit;
  logic [BIT_W-1:0]               hit_bit;
  logic [BIT_W-1:0]               fix_bit;
  dsa_pkg::word_t                 fix_onehot;
  dsa_pkg::op_e                   req_op;
  logic                           start_beyond;
  logic                           slot_exists;

  assign req_op       = dsa_pkg::op_e'(req_i.operation);
  assign start_beyond = 32'(auto_start_q) >= 32'(dsa_pkg::SEARCH_LIMIT);
  assign slot_exists  = 32'(req_i.slot_index) < 32'(dsa_pkg::SLOT_COUNT);

  assign free_word  = rd_valid_q ? ~rd_data_q : '1;
  assign start_mask = dsa_pkg::word_t'('1) << auto_start_q[BIT_W-1:0];
  assign cand       = free_word & (first_q ? start_mask : '1)
                    & ((row_q == LAST_ROW_IDX) ? dsa_pkg::LAST_MASK : '1);
  assign hit        = |cand;
  assign fix_bit    = slot_q[BIT_W-1:0];
  assign fix_onehot = dsa_pkg::word_t'(1) << fix_bit;

  // Output register takes a new result once it is empty or draining
  assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  // Lowest free slot in the current row
  always_comb begin
    hit_bit = '0;
    for (int b = dsa_pkg::WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) hit_bit = BIT_W'(b);
    end
  end

  // Map update, issued from the evaluation cycle only
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = ~free_word;
    if (state_q == S_EVAL) begin
      unique case (op_q)
        dsa_pkg::OP_AUTO: begin
          mem_we    = hit;
          mem_wdata = ~free_word | (dsa_pkg::word_t'(1) << hit_bit);
        end
        dsa_pkg::OP_FIXED: begin
          mem_we    = free_word[fix_bit];
          mem_wdata = ~free_word | fix_onehot;
        end
        dsa_pkg::OP_FREE: begin
          mem_we    = 1'b1;
          mem_wdata = ~free_word & ~fix_onehot;
        end
        default: begin
          mem_we    = 1'b0;
        end
      endcase
    end
  end

  // Prefetch the next row while the current one is evaluated
  assign rd_addr = (state_q == S_EVAL && row_q != LAST_ROW_IDX) ? ROW_W'(row_q + 1'b1) : row_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) used_mem[row_q] <= mem_wdata;
    rd_data_q <= used_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (mem_we) row_valid_q[row_q] <= 1'b1;
      rd_valid_q <= row_valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_start_q <= '0;
      incr_q       <= dsa_pkg::INCR_RESET;
      cpu_base_q   <= '0;
      gpu_base_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (dsa_pkg::cfg_reg_e'(cfg_idx_i))
        dsa_pkg::CFG_AUTO_START:  auto_start_q <= cfg_wdata_i[SLOT_W-1:0];
        dsa_pkg::CFG_HANDLE_INCR: incr_q       <= cfg_wdata_i[dsa_pkg::INCR_W-1:0];
        dsa_pkg::CFG_CPU_BASE:    cpu_base_q   <= cfg_wdata_i;
        dsa_pkg::CFG_GPU_BASE:    gpu_base_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= dsa_pkg::OP_NONE;
      slot_q       <= '0;
      row_q        <= '0;
      first_q      <= 1'b0;
      res_status_q <= dsa_pkg::ST_OK;
      res_slot_q   <= '0;
      hnd_q        <= 1'b0;
      prod_q       <= '0;
      cpu_sum_q    <= '0;
      gpu_sum_q    <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= dsa_pkg::ST_OK;
      rsp_slot_q   <= '0;
      rsp_cpu_q    <= '0;
      rsp_gpu_q    <= '0;
    end else begin
      if (rsp_load) rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q    <= req_op;
            slot_q  <= req_i.slot_index;
            first_q <= 1'b1;
            hnd_q   <= 1'b0;
            unique case (req_op)
              dsa_pkg::OP_AUTO: begin
                row_q      <= ROW_W'(auto_start_q >> BIT_W);
                res_slot_q <= '0;
                if (start_beyond) begin
                  res_status_q <= dsa_pkg::ST_NO_FREE;
                  state_q      <= S_DONE;
                end else begin
                  res_status_q <= dsa_pkg::ST_OK;
                  state_q      <= S_READ;
                end
              end
              dsa_pkg::OP_FIXED, dsa_pkg::OP_FREE: begin
                row_q <= ROW_W'(req_i.slot_index >> BIT_W);
                if (slot_exists) begin
                  res_status_q <= dsa_pkg::ST_OK;
                  res_slot_q   <= '0;
                  state_q      <= S_READ;
                end else if (req_op == dsa_pkg::OP_FIXED) begin
                  // nonexistent slot: fixed request fails, free is ignored
                  res_status_q <= dsa_pkg::ST_IN_USE;
                  res_slot_q   <= '0;
                  state_q      <= S_DONE;
                end else begin
                  res_status_q <= dsa_pkg::ST_OK;
                  res_slot_q   <= req_i.slot_index;
                  state_q      <= S_DONE;
                end
              end
              default: begin
                res_status_q <= dsa_pkg::ST_OK;
                res_slot_q   <= '0;
                state_q      <= S_DONE;
              end
            endcase
          end
        end

        S_READ: begin
          state_q <= S_EVAL;
        end

        S_EVAL: begin
          unique case (op_q)
            dsa_pkg::OP_AUTO: begin
              if (hit) begin
                res_slot_q <= SLOT_W'({row_q, hit_bit});
                hnd_q      <= 1'b1;
                state_q    <= S_MUL;
              end else if (row_q == LAST_ROW_IDX) begin
                res_status_q <= dsa_pkg::ST_NO_FREE;
                state_q      <= S_DONE;
              end else begin
                // next row was prefetched this cycle
                row_q   <= ROW_W'(row_q + 1'b1);
                first_q <= 1'b0;
              end
            end
            dsa_pkg::OP_FIXED: begin
              if (free_word[fix_bit]) begin
                res_slot_q <= slot_q;
                hnd_q      <= 1'b1;
                state_q    <= S_MUL;
              end else begin
                res_status_q <= dsa_pkg::ST_IN_USE;
                state_q      <= S_DONE;
              end
            end
            dsa_pkg::OP_FREE: begin
              res_slot_q <= slot_q;
              state_q    <= S_DONE;
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end

        S_MUL: begin
          prod_q  <= dsa_pkg::PROD_W'(res_slot_q) * dsa_pkg::PROD_W'(incr_q);
          state_q <= S_ADD;
        end

        S_ADD: begin
          cpu_sum_q <= cpu_base_q + dsa_pkg::HANDLE_W'(prod_q);
          gpu_sum_q <= gpu_base_q + dsa_pkg::HANDLE_W'(prod_q);
          state_q   <= S_DONE;
        end

        S_DONE: begin
          if (rsp_load) begin
            rsp_status_q <= res_status_q;
            rsp_slot_q   <= res_slot_q;
            rsp_cpu_q    <= hnd_q ? cpu_sum_q : '0;
            rsp_gpu_q    <= hnd_q ? gpu_sum_q : '0;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.granted_slot = rsp_slot_q;
  assign rsp_o.cpu_handle   = rsp_cpu_q;
  assign rsp_o.gpu_handle   = rsp_gpu_q;

  `DSA_ASSERT(a_map_write_in_eval, mem_we |-> state_q == S_EVAL, "map written outside evaluation")
  `DSA_ASSERT(a_fail_clears_fields, (rsp_o.valid && rsp_o.status != dsa_pkg::ST_OK) |-> (rsp_o.granted_slot == '0 && rsp_o.cpu_handle == '0 && rsp_o.gpu_handle == '0), "failed response carries data")
  `DSA_ASSERT_NEXT(a_busy_after_accept, req_i.valid && req_i.ready, state_q != S_IDLE, "sequencer idle after accept")
  `DSA_ASSERT(a_row_in_range, state_q == S_EVAL |-> row_q <= LAST_ROW_IDX, "scan past last row")

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Descriptor slot allocator core testbench
// Directed and random allocate/claim/free traffic against a bitmap model
// of the slot map; responses are checked in order, field by field, under
// several register settings and with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dsa_pkg::*;

  typedef struct {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [63:0]        cpu;
    logic [63:0]        gpu;
  } slot_grant_t;

  // Slot map model: predicts each response at request transfer time
  class slot_ledger;
    bit                free_map [SLOT_COUNT];
    logic [SLOT_W-1:0] auto_start;
    logic [INCR_W-1:0] incr;
    logic [63:0]       cpu_base;
    logic [63:0]       gpu_base;
    slot_grant_t       grants_due [$];
    int                errors;

    function new();
      foreach (free_map[i]) free_map[i] = 1'b1;
      auto_start = '0;
      incr       = INCR_RESET;
      cpu_base   = '0;
      gpu_base   = '0;
      errors     = 0;
    endfunction

    function void set_regs(logic [SLOT_W-1:0] start, logic [INCR_W-1:0] step,
                           logic [63:0] cpu, logic [63:0] gpu);
      auto_start = start;
      incr       = step;
      cpu_base   = cpu;
      gpu_base   = gpu;
    endfunction

    function logic [63:0] handle_at(logic [63:0] base, int unsigned slot);
      return base + 64'(slot) * 64'(incr);
    endfunction

    function void grant(int unsigned slot, ref slot_grant_t g);
      free_map[slot] = 1'b0;
      g.slot = SLOT_W'(slot);
      g.cpu  = handle_at(cpu_base, slot);
      g.gpu  = handle_at(gpu_base, slot);
    endfunction

    function void note_request(op_e op, logic [SLOT_W-1:0] slot);
      slot_grant_t g;
      bit          found;
      g = '{ST_OK, '0, '0, '0};
      found = 1'b0;
      case (op)
        OP_AUTO: begin
          for (int i = int'(auto_start); i < SEARCH_LIMIT && !found; i++) begin
            if (free_map[i]) begin
              grant(i, g);
              found = 1'b1;
            end
          end
          if (!found) g.status = ST_NO_FREE;
        end
        OP_FIXED: begin
          if (int'(slot) < SLOT_COUNT && free_map[slot]) grant(slot, g);
          else g.status = ST_IN_USE;
        end
        OP_FREE: begin
          if (int'(slot) < SLOT_COUNT) free_map[slot] = 1'b1;
          g.slot = slot;
        end
        default: ;
      endcase
      grants_due.push_back(g);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_response(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                                 logic [63:0] cpu, logic [63:0] gpu);
      slot_grant_t want;
      if (grants_due.size() == 0) begin
        $error("response with nothing outstanding: status %0d slot %0d", status, slot);
        errors++;
        return;
      end
      want = grants_due.pop_front();
      compare("status", 64'(want.status), 64'(status));
      compare("granted_slot", 64'(want.slot), 64'(slot));
      compare("cpu_handle", want.cpu, cpu);
      compare("gpu_handle", want.gpu, gpu);
    endfunction

    function int pending();
      return grants_due.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dsa_req_if req_if ();
  dsa_rsp_if rsp_if ();

  descriptor_slot_allocator_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  slot_ledger ledger = new();

  int unsigned send_idle;
  int unsigned recv_stall;
  bit          hold_request;
  int          hold_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Response side: check each transfer, then pick next ready
  initial begin
    rsp_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready)
        ledger.check_response(rsp_if.status, rsp_if.granted_slot,
                              rsp_if.cpu_handle, rsp_if.gpu_handle);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic send_item(op_e op, logic [SLOT_W-1:0] slot);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle && gap < 40) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.slot_index <= slot;
    do @(posedge clk); while (!req_if.ready);
    ledger.note_request(op, slot);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // All four registers back to back; write enable drops after the last
  task automatic load_regs(logic [SLOT_W-1:0] start, logic [INCR_W-1:0] step,
                           logic [63:0] cpu, logic [63:0] gpu);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_AUTO_START;
    cfg_wdata <= 64'(start);
    @(posedge clk);
    cfg_idx   <= CFG_HANDLE_INCR;
    cfg_wdata <= 64'(step);
    @(posedge clk);
    cfg_idx   <= CFG_CPU_BASE;
    cfg_wdata <= cpu;
    @(posedge clk);
    cfg_idx   <= CFG_GPU_BASE;
    cfg_wdata <= gpu;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ledger.set_regs(start, step, cpu, gpu);
  endtask

  function automatic op_e pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return OP_AUTO;
    if (r < 65) return OP_FIXED;
    if (r < 95) return OP_FREE;
    return OP_NONE;
  endfunction

  // Half the slots fall in a window above auto_start so the map fills there
  function automatic logic [SLOT_W-1:0] pick_slot();
    int unsigned lo;
    int unsigned hi;
    lo = ledger.auto_start;
    hi = (lo > 960) ? 1023 : lo + 63;
    if ($urandom_range(1)) return SLOT_W'($urandom_range(hi, lo));
    return SLOT_W'($urandom_range(1023));
  endfunction

  initial begin
    logic [SLOT_W-1:0] start;
    logic [INCR_W-1:0] step;
    logic [63:0]       cpu;
    logic [63:0]       gpu;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_AUTO_START;
    cfg_wdata         <= '0;
    req_if.valid      <= 1'b0;
    req_if.operation  <= OP_AUTO;
    req_if.slot_index <= '0;
    send_idle    = 0;
    recv_stall   = 0;
    hold_request = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset register values
    send_item(OP_AUTO, 10'd77);
    send_item(OP_AUTO, 10'd0);
    send_item(OP_FIXED, 10'd1023);
    send_item(OP_FIXED, 10'd1023);
    send_item(OP_FIXED, 10'd0);
    send_item(OP_FREE, 10'd0);
    send_item(OP_FREE, 10'd0);       // already free
    send_item(OP_AUTO, 10'd1023);
    send_item(OP_NONE, 10'd1023);
    send_item(OP_FREE, 10'd1023);

    // Top slot only, increment 256, handles wrap
    wait_drained();
    load_regs(10'd1023, 9'd256, '1, 64'h8000_0000_0000_0000);
    send_item(OP_AUTO, 10'd0);
    send_item(OP_AUTO, 10'd0);       // nothing free at or above start
    send_item(OP_FIXED, 10'd1023);
    send_item(OP_FREE, 10'd1023);
    send_item(OP_FIXED, 10'd1023);

    // Zero increment gives the base
    wait_drained();
    load_regs(10'd0, 9'd0, {$urandom, $urandom}, {$urandom, $urandom});
    send_item(OP_FIXED, 10'd512);
    send_item(OP_AUTO, 10'd0);

    wait_drained();
    load_regs(10'd1000, 9'd511, {$urandom, $urandom}, '0);
    send_item(OP_AUTO, 10'd0);
    send_item(OP_FIXED, 10'd1023);

    for (int phase = 0; phase < 4; phase++) begin
      for (int sub = 0; sub < 2; sub++) begin
        wait_drained();
        case (phase)
          0: begin send_idle = 0;  recv_stall = 0;  end
          1: begin send_idle = 62; recv_stall = 0;  end
          2: begin send_idle = 0;  recv_stall = 62; end
          default: begin send_idle = 32; recv_stall = 32; end
        endcase
        case ($urandom_range(2))
          0: start = '0;
          1: start = SLOT_W'($urandom_range(1023));
          default: start = SLOT_W'($urandom_range(1023, 990));
        endcase
        case ($urandom_range(2))
          0: step = 9'd1;
          1: step = 9'd256;
          default: step = INCR_W'($urandom_range(256, 1));
        endcase
        cpu = $urandom_range(3) == 0 ? '1 : {$urandom, $urandom};
        gpu = {$urandom, $urandom};
        load_regs(start, step, cpu, gpu);
        for (int n = 0; n < 69; n++) begin
          // long receiver hold-off while requests keep coming
          if (phase == 0 && sub == 0 && n == 20) hold_request = 1'b1;
          send_item(pick_op(), pick_slot());
        end
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/dsa_pkg.sv
rtl/core/dsa_if.sv
rtl/core/descriptor_slot_allocator_core.sv
tb/tb.sv
